// ===== rtl/pcgr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pcgr_pkg: shared types and constants
// Opcodes, multiplier constants and the controller/datapath command struct.
// ---------------------------------------------------------------------------
package pcgr_pkg;

    localparam logic [63:0] MULT_HI = 64'hfa744cb0f736314b;
    localparam logic [63:0] MULT_LO = 64'ha95189b5eb77099f;

    localparam logic [1:0] OP_RAW    = 2'd0;
    localparam logic [1:0] OP_RANGE  = 2'd1;
    localparam logic [1:0] OP_RESEED = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic CFG_SEED   = 1'b0;
    localparam logic CFG_STREAM = 1'b1;

    // datapath micro-operations
    typedef enum logic [3:0] {
        DOP_NONE   = 4'd0,
        DOP_LOAD   = 4'd1,  // latch limits, swap, form bound
        DOP_MSTART = 4'd2,  // latch step operands
        DOP_MUL    = 4'd3,  // one 32x32 partial product
        DOP_MFIN   = 4'd4,  // finish LCG step, latch output
        DOP_CLR    = 4'd5,  // reseed: clear state, set increment
        DOP_ADDSD  = 4'd6,  // reseed: add seed
        DOP_DSTART = 4'd7,  // start modulo
        DOP_DIV    = 4'd8,  // one restoring-division bit
        DOP_RES    = 4'd9   // form result
    } t_dop;

    typedef enum logic [1:0] {
        RES_ZERO  = 2'd0,
        RES_RAW   = 2'd1,
        RES_RANGE = 2'd2
    } t_rsel;

    typedef struct packed {
        t_dop  op;
        logic  div_thr;  // modulo target: 1 threshold, 0 draw
        t_rsel rsel;
    } t_cmd;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic bound_zero;
        logic accept;    // draw >= threshold
    } t_sts;

endpackage
`default_nettype wire

// ===== rtl/pcgr_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pcgr_datapath: LCG state, serial multiplier and serial modulo unit
// Multiplier does one 32x32 product per cycle; modulo one bit per cycle.
// ---------------------------------------------------------------------------
module pcgr_datapath
    import pcgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_sts             o_sts,
    input  wire logic [63:0] i_seed,
    input  wire logic [63:0] i_stream,
    input  wire logic [63:0] i_lo,
    input  wire logic [63:0] i_hi,
    output logic      [63:0] o_result
);

    logic [63:0] r_xl, r_xh, r_incl;
    logic        r_inch;
    logic [63:0] r_al, r_ah;
    logic [127:0] r_acc;
    logic [2:0]  r_mcnt;
    logic [63:0] r_draw, r_thr, r_bound, r_min;
    logic [63:0] r_num, r_quo_rem;
    logic [64:0] r_rem;
    logic [6:0]  r_dcnt;
    logic [63:0] r_res;

    // partial product select: a is {xh,xl} low 128, b is mult
    logic [31:0] w_pa, w_pb;
    logic [63:0] w_pp;
    logic [6:0]  w_sh;
    always_comb begin
        w_pa = 32'd0; w_pb = 32'd0; w_sh = 7'd0;
        case (r_mcnt)
            3'd0: begin w_pa = r_al[31:0];  w_pb = MULT_LO[31:0];  w_sh = 7'd0;  end
            3'd1: begin w_pa = r_al[31:0];  w_pb = MULT_LO[63:32]; w_sh = 7'd32; end
            3'd2: begin w_pa = r_al[63:32]; w_pb = MULT_LO[31:0];  w_sh = 7'd32; end
            3'd3: begin w_pa = r_al[63:32]; w_pb = MULT_LO[63:32]; w_sh = 7'd64; end
            3'd4: begin w_pa = r_ah[31:0];  w_pb = MULT_LO[31:0];  w_sh = 7'd64; end
            3'd5: begin w_pa = r_al[31:0];  w_pb = MULT_HI[31:0];  w_sh = 7'd64; end
            3'd6: begin w_pa = r_ah[31:0];  w_pb = MULT_LO[63:32]; w_sh = 7'd96; end
            3'd7: begin w_pa = r_ah[63:32]; w_pb = MULT_LO[31:0];  w_sh = 7'd96; end
            default: ;
        endcase
        w_pp = 64'(w_pa) * 64'(w_pb);
    end
    // high-only terms for last products (a_lo_hi*MULT_HI_lo and a_lo_lo*MULT_HI_hi)
    logic [31:0] w_x1, w_x2;
    assign w_x1 = r_al[63:32] * MULT_HI[31:0];
    assign w_x2 = r_al[31:0] * MULT_HI[63:32];

    logic [127:0] w_sum;
    assign w_sum = r_acc + (128'(w_pp) << w_sh);
    logic [127:0] w_next;
    assign w_next = {r_acc[127:96] + w_x1 + w_x2, r_acc[95:0]}
                    + {63'd0, r_inch, r_incl};

    logic [63:0] w_mix, w_rot;
    assign w_mix = r_ah ^ r_al;
    assign w_rot = (w_mix >> r_ah[63:58]) | (w_mix << (7'd64 - {1'b0, r_ah[63:58]}));

    logic [64:0] w_trial;
    assign w_trial = {r_rem[63:0], r_num[63]} - {1'b0, r_bound};

    logic [63:0] w_slo, w_shi;
    assign w_slo = ($signed(i_lo) > $signed(i_hi)) ? i_hi : i_lo;
    assign w_shi = ($signed(i_lo) > $signed(i_hi)) ? i_lo : i_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_xl <= 64'd0; r_xh <= 64'd0; r_incl <= 64'd1; r_inch <= 1'b0;
            r_mcnt <= 3'd0; r_dcnt <= 7'd0;
        end else begin
            case (i_cmd.op)
                DOP_LOAD: begin
                    r_min <= w_slo;
                    r_bound <= w_shi - w_slo + 64'd1;
                end
                DOP_MSTART: begin
                    r_al <= r_xl; r_ah <= r_xh; r_acc <= 128'd0; r_mcnt <= 3'd0;
                end
                DOP_MUL: begin
                    r_acc <= w_sum; r_mcnt <= r_mcnt + 3'd1;
                end
                DOP_MFIN: begin
                    r_xl <= w_next[63:0]; r_xh <= w_next[127:64]; r_draw <= w_rot;
                end
                DOP_CLR: begin
                    r_xl <= 64'd0; r_xh <= 64'd0;
                    r_incl <= {i_stream[62:0], 1'b1}; r_inch <= i_stream[63];
                end
                DOP_ADDSD: begin
                    {r_xh, r_xl} <= {r_xh, r_xl} + {64'd0, i_seed};
                end
                DOP_DSTART: begin
                    r_num <= i_cmd.div_thr ? (64'd0 - r_bound) : r_draw;
                    r_rem <= 65'd0; r_dcnt <= 7'd0;
                end
                DOP_DIV: begin
                    r_rem <= w_trial[64] ? {r_rem[63:0], r_num[63]} : w_trial;
                    r_num <= {r_num[62:0], 1'b0};
                    r_dcnt <= r_dcnt + 7'd1;
                    if (r_dcnt == 7'd63 && i_cmd.div_thr)
                        r_thr <= w_trial[64] ? {r_rem[62:0], r_num[63]} : w_trial[63:0];
                end
                DOP_RES: begin
                    case (i_cmd.rsel)
                        RES_RAW:   r_res <= r_draw;
                        RES_RANGE: r_res <= r_rem[63:0] + r_min;
                        default:   r_res <= 64'd0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    assign r_quo_rem = r_rem[63:0];
    assign o_sts.mul_done   = (r_mcnt == 3'd7);
    assign o_sts.div_done   = (r_dcnt == 7'd64);
    assign o_sts.bound_zero = (r_bound == 64'd0);
    assign o_sts.accept     = (r_draw >= r_thr) && (r_quo_rem == r_quo_rem);
    assign o_result = r_res;

endmodule
`default_nettype wire

// ===== rtl/pcgr_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pcgr_ctrl: operation sequencer
// Walks the datapath through steps, reseed and rejection sampling.
// ---------------------------------------------------------------------------
module pcgr_ctrl
    import pcgr_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_stall,
    input  wire logic [1:0] i_opcode,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_cmd            o_cmd,
    input  wire t_sts       i_sts
);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_LOAD  = 12'b000000000010,
        S_MST   = 12'b000000000100,
        S_MUL   = 12'b000000001000,
        S_MFIN  = 12'b000000010000,
        S_TSTA  = 12'b000000100000,
        S_TDIV  = 12'b000001000000,
        S_CHK   = 12'b000010000000,
        S_DDIV  = 12'b000100000000,
        S_ADD   = 12'b001000000000,
        S_RES   = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [1:0] r_op, n_op;
    logic       r_pass, n_pass;   // reseed step count
    logic       r_valid, n_valid;
    t_cmd       w_cmd;

    always_comb begin
        n_state = r_state; n_op = r_op; n_pass = r_pass; n_valid = r_valid;
        w_cmd = '{op: DOP_NONE, div_thr: 1'b0, rsel: RES_ZERO};
        if (r_valid && !i_stall) n_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_valid && !r_valid) begin
                    n_op = i_opcode; n_pass = 1'b0;
                    case (i_opcode)
                        OP_RAW:    begin w_cmd.op = DOP_MSTART; n_state = S_MUL; end
                        OP_RANGE:  begin w_cmd.op = DOP_LOAD; n_state = S_LOAD; end
                        OP_RESEED: begin w_cmd.op = DOP_CLR; n_state = S_MST; end
                        default:   n_state = S_RES;
                    endcase
                end
            end
            S_LOAD: begin
                if (i_sts.bound_zero) n_state = S_MST;
                else begin
                    w_cmd.op = DOP_DSTART; w_cmd.div_thr = 1'b1; n_state = S_TDIV;
                end
            end
            S_TDIV: begin
                w_cmd.op = DOP_DIV; w_cmd.div_thr = 1'b1;
                if (i_sts.div_done) begin w_cmd.op = DOP_NONE; n_state = S_MST; end
            end
            S_MST:  begin w_cmd.op = DOP_MSTART; n_state = S_MUL; end
            S_MUL: begin
                w_cmd.op = DOP_MUL;
                if (i_sts.mul_done) n_state = S_MFIN;
            end
            S_MFIN: begin
                w_cmd.op = DOP_MFIN;
                if (r_op == OP_RESEED) begin
                    if (r_pass) n_state = S_RES;
                    else n_state = S_ADD;
                    n_pass = 1'b1;
                end else if (r_op == OP_RANGE && !i_sts.bound_zero) n_state = S_CHK;
                else n_state = S_RES;
            end
            S_ADD:  begin w_cmd.op = DOP_ADDSD; n_state = S_MST; end
            S_CHK: begin
                if (i_sts.accept) begin w_cmd.op = DOP_DSTART; n_state = S_DDIV; end
                else n_state = S_MST;
            end
            S_DDIV: begin
                w_cmd.op = DOP_DIV;
                if (i_sts.div_done) begin w_cmd.op = DOP_NONE; n_state = S_RES; end
            end
            S_RES: begin
                w_cmd.op = DOP_RES;
                if (r_op == OP_RAW) w_cmd.rsel = RES_RAW;
                else if (r_op == OP_RANGE)
                    w_cmd.rsel = i_sts.bound_zero ? RES_RAW : RES_RANGE;
                n_state = S_OUT;
            end
            S_OUT: begin n_valid = 1'b1; n_state = S_IDLE; end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_valid <= 1'b0; r_op <= OP_RAW; r_pass <= 1'b0;
        end else begin
            r_state <= n_state; r_valid <= n_valid; r_op <= n_op; r_pass <= n_pass;
        end
    end

    assign o_stall = (r_state != S_IDLE) || r_valid;
    assign o_valid = r_valid;
    assign o_cmd   = w_cmd;

endmodule
`default_nettype wire

// ===== rtl/pcg128_random_with_range.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// pcg128_random_with_range: PCG XSL-RR 128/64 generator with ranged draws
// Each LCG step runs 8 partial products on a 32x32 multiplier, plus two high-only terms.
// A raw draw takes one LCG step, a reseed two and a full-range draw one; other
// ranged draws add two modulo passes plus one more step per rejected draw.
// One item at a time; the next is taken once the result has been taken.
// Synchronous active-low reset: state zero, increment one, counters and config zero.
// ---------------------------------------------------------------------------
module pcg128_random_with_range
    import pcgr_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_opcode,
    input  wire logic signed [63:0] i_range_low,
    input  wire logic signed [63:0] i_range_high,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic signed [63:0] o_random_value,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [63:0] i_cfg_data
);

    logic [63:0] r_seed, r_stream;
    t_cmd w_cmd;
    t_sts w_sts;
    logic [63:0] w_res;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= 64'd0; r_stream <= 64'd0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_SEED) r_seed <= i_cfg_data;
            if (i_cfg_index == CFG_STREAM) r_stream <= i_cfg_data;
        end
    end

    pcgr_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_opcode,
        .o_valid, .i_stall, .o_cmd(w_cmd), .i_sts(w_sts)
    );

    // limits are latched by the datapath at the accepting edge
    pcgr_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .o_sts(w_sts),
        .i_seed(r_seed), .i_stream(r_stream), .i_lo(i_range_low), .i_hi(i_range_high),
        .o_result(w_res)
    );

    assign o_random_value = w_res;

endmodule
`default_nettype wire
